@@ src/pcti_pkg.sv @@
package pcti_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Q1.16 percentile fraction
  localparam int          FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE  = 17'h10000;

  typedef struct packed {
    logic [1:0]          func;
    logic signed [31:0]  sample;
    logic [16:0]         fraction;
  } pcti_in_t;

  typedef struct packed {
    logic signed [31:0]  value;
    logic [1:0]          status;
    logic [10:0]         sample_count;
  } pcti_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_Q_MUL,
    ST_Q_IDX,
    ST_Q_LAST,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_STEP,
    ST_Q_ADD,
    ST_FIN
  } pcti_state_t;

endpackage

@@ src/percentile_interpolate_top.sv @@
// Percentile of a bounded set of signed samples, by linear interpolation.
// Input channel (in_valid/in_ready/in_data) takes one item: func add appends a
// sample in sorted order, func query returns the percentile for a Q1.16
// fraction, func clear empties the set. Every item gives exactly one result
// item on the output channel (out_valid/out_ready/out_data), carrying value,
// status and the sample count after the item.
//
// Items are handled one at a time; in_ready is high only while the sequencer
// waits for work, and the next item is taken in the cycle after the result of
// the previous one is loaded at the soonest. A clear, an unused func, an add to
// a full set and a query on an empty set go straight to the finish step. An add
// to an empty set writes the sample at once; otherwise the walk reads down from
// the top entry, moving up each held sample greater than the new one, then
// writes the new one in the gap. A query forms the position, then reads the
// last sample when at or past it, else both neighbours, and interpolates.
// The walk moves one entry of the sample memory per cycle; a query uses one
// shared multiplier twice (position, then step).
// Reset (rst, synchronous) empties the set and drops any pending result; the
// sample memory is not cleared, only entries below the count are read. While
// the receiver stalls, a finished result sits in the output register; one more
// item may be accepted, and its result waits in the sequencer until taken.
module percentile_interpolate_top #(
  parameter int MAX_SAMPLES  = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcti_pkg::pcti_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcti_pkg::pcti_out_t  out_data
);

  import pcti_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int MW = (SAMPLE_WIDTH > AW) ? SAMPLE_WIDTH : AW;
  localparam int PW = MW + FRAC_BITS + 1;

  pcti_state_t state, state_next;

  // Control registers
  logic [CW-1:0] count;
  logic [AW-1:0] ptr;

  // Item and datapath registers
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic [FRAC_BITS:0]             frac;
  logic [FRAC_BITS-1:0]           part;
  logic [SAMPLE_WIDTH-1:0]        lo;
  logic [SAMPLE_WIDTH-1:0]        diff;
  logic [PW-1:0]                  prod;
  logic [SAMPLE_WIDTH-1:0]        res_value;
  logic [1:0]                     res_status;

  // Combinational
  logic                           accept;
  logic                           out_free;
  logic                           full;
  logic                           empty;
  logic                           cmp_gt;
  logic                           at_end;
  logic                           ins_done;
  logic [CW-1:0]                  cnt_m1;
  logic [MW:0]                    idx;
  logic signed [SAMPLE_WIDTH-1:0] smp_in;
  logic [FRAC_BITS:0]             frac_in;
  logic [1:0]                     status_in;
  logic [MW-1:0]                  mul_a;
  logic [FRAC_BITS:0]             mul_b;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [SAMPLE_WIDTH-1:0]        wr_data;
  logic [AW-1:0]                  rd_addr;
  logic [SAMPLE_WIDTH-1:0]        rd_data;

  pcti_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = (count == CW'(MAX_SAMPLES));
  assign empty    = (count == '0);
  assign cnt_m1   = count - CW'(1);

  // Keep the low SAMPLE_WIDTH bits of the sample; they are read as signed
  assign smp_in  = SAMPLE_WIDTH'($unsigned(in_data.sample));
  // Saturate fractions above one
  assign frac_in = (in_data.fraction > FRAC_ONE) ? FRAC_ONE : in_data.fraction;

  // Held sample above the new one: move it up a place
  assign cmp_gt = $signed(rd_data) > smp;

  // Integer part of the interpolation position
  assign idx    = prod[MW+FRAC_BITS:FRAC_BITS];
  assign at_end = (idx >= (MW+1)'(cnt_m1));

  assign ins_done = ((state == ST_INS_CMP) && !cmp_gt) || (state == ST_INS_PUT);

  always_comb begin
    status_in = STATUS_OK;
    if (in_data.func == FUNC_ADD && full) begin
      status_in = STATUS_FULL;
    end else if (in_data.func == FUNC_QUERY && empty) begin
      status_in = STATUS_EMPTY;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_ADD: begin
              if (full) begin
                state_next = ST_FIN;
              end else if (empty) begin
                state_next = ST_INS_PUT;
              end else begin
                state_next = ST_INS_RD;
              end
            end
            FUNC_QUERY: begin
              state_next = empty ? ST_FIN : ST_Q_MUL;
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_INS_RD:  state_next = ST_INS_CMP;
      ST_INS_CMP: begin
        if (!cmp_gt) begin
          state_next = ST_FIN;
        end else if (ptr == AW'(1)) begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_next = ST_FIN;
      ST_Q_MUL:   state_next = ST_Q_IDX;
      ST_Q_IDX:   state_next = at_end ? ST_Q_LAST : ST_Q_LO;
      ST_Q_LAST:  state_next = ST_FIN;
      ST_Q_LO:    state_next = ST_Q_HI;
      ST_Q_HI:    state_next = ST_Q_STEP;
      ST_Q_STEP:  state_next = ST_Q_ADD;
      ST_Q_ADD:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: in_ready, memory ports and multiplier operands
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = ptr;
    wr_en    = 1'b0;
    wr_addr  = ptr;
    wr_data  = smp;
    mul_a    = MW'($unsigned(cnt_m1));
    mul_b    = frac;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_INS_RD: rd_addr = ptr - AW'(1);
      ST_INS_CMP: begin
        // Fetch the next lower entry while this one is placed
        rd_addr = ptr - AW'(2);
        wr_en   = 1'b1;
        wr_data = cmp_gt ? rd_data : smp;
      end
      ST_INS_PUT: wr_en = 1'b1;
      ST_Q_IDX:   rd_addr = at_end ? cnt_m1[AW-1:0] : idx[AW-1:0];
      ST_Q_STEP: begin
        mul_a = MW'(diff);
        mul_b = {1'b0, part};
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_data.func == FUNC_CLEAR) begin
        count <= '0;
      end else if (ins_done) begin
        count <= count + CW'(1);
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // Shared multiplier, registered
    prod <= PW'(mul_a) * PW'(mul_b);
    if (accept) begin
      smp        <= smp_in;
      frac       <= frac_in;
      ptr        <= count[AW-1:0];
      res_value  <= '0;
      res_status <= status_in;
    end
    unique case (state)
      ST_INS_CMP: begin
        if (cmp_gt) begin
          ptr <= ptr - AW'(1);
        end
      end
      ST_Q_IDX: begin
        part <= prod[FRAC_BITS-1:0];
        ptr  <= idx[AW-1:0] + AW'(1);
      end
      ST_Q_LAST: res_value <= rd_data;
      ST_Q_LO:   lo <= rd_data;
      // Neighbours are sorted, so the wrapped difference is the true one
      ST_Q_HI:   diff <= rd_data - lo;
      ST_Q_ADD:  res_value <= lo + prod[SAMPLE_WIDTH+FRAC_BITS-1:FRAC_BITS];
      default: begin
      end
    endcase
    if (state == ST_FIN && out_free) begin
      out_data <= '{value:        32'($unsigned(res_value)),
                    status:       res_status,
                    sample_count: 11'(count)};
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result loaded outside the finish step");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP && cmp_gt) |=> (ptr == $past(ptr) - AW'(1)))
    else $error("insertion walk did not step down");

  a_query_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_IDX) |-> (rd_addr <= cnt_m1[AW-1:0]))
    else $error("query read beyond held samples");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && !out_ready) |=> (state == ST_FIN))
    else $error("result left the sequencer while output stalled");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.func == FUNC_ADD && full)
      |=> (state == ST_FIN && count == $past(count)))
    else $error("sample added to a full store");

endmodule

@@ src/pcti_ram.sv @@
module pcti_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
